// ===== hw/rtl/pffb_pkg.sv =====
// Shared types and constants for the page framebuffer fill/blit block.
// No dependencies.
package pffb_pkg;
   localparam int COLUMNS   = 128;
   localparam int PAGES     = 8;
   localparam int SRC_DEPTH = 1024;
   localparam int ROWS      = PAGES * 8;
   localparam int FB_BYTES  = COLUMNS * PAGES;
   localparam int FB_AW     = $clog2(FB_BYTES);
   localparam int SRC_AW    = $clog2(SRC_DEPTH);
   localparam int PG_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int COL_W     = $clog2(COLUMNS);

   localparam logic [1:0] REQ_SRC_WR = 2'd0;
   localparam logic [1:0] REQ_FILL   = 2'd1;
   localparam logic [1:0] REQ_BLIT   = 2'd2;
   localparam logic [1:0] REQ_FB_RD  = 2'd3;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_REFUSED = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   localparam logic [7:0] CSR_STRIDE = 8'd0;
   localparam logic [7:0] CSR_MONO   = 8'd1;

   // classified command handed from front to back
   typedef struct packed {
      logic [1:0] op;        // REQ_* ; only valid ops reach back as work
      logic       work;      // 0: result only
      logic [1:0] status;
      logic       color;
      logic [6:0] x0;
      logic [5:0] y0;
      logic [6:0] x1;
      logic [5:0] y1;
      logic [9:0] scol;
      logic [9:0] srow;
      logic [9:0] addr;
      logic [7:0] bin;
   } cmd_type;
endpackage

// ===== hw/rtl/pffb_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module pffb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== hw/rtl/pffb_front.sv =====
// Front end: accepts requests, checks coordinates, builds commands.
// Depends on pffb_pkg.
module pffb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic              color,
   input  logic [6:0]        x_first,
   input  logic [5:0]        y_first,
   input  logic [6:0]        x_last,
   input  logic [5:0]        y_last,
   input  logic [9:0]        src_col,
   input  logic [9:0]        src_row,
   input  logic [7:0]        blit_width,
   input  logic [6:0]        blit_height,
   input  logic [9:0]        byte_addr,
   input  logic [7:0]        byte_in,
   input  logic              mono,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output pffb_pkg::cmd_type cmd
);
   import pffb_pkg::*;
   cmd_type c;
   logic bad;
   logic [8:0] xe;
   logic [7:0] ye;
   always_comb begin
      c = '0;
      c.op = req_type; c.color = color;
      c.x0 = x_first; c.y0 = y_first; c.x1 = x_last; c.y1 = y_last;
      c.scol = src_col; c.srow = src_row; c.addr = byte_addr; c.bin = byte_in;
      xe = {2'b0, x_first} + {1'b0, blit_width};
      ye = {2'b0, y_first} + {1'b0, blit_height};
      bad = 1'b0;
      c.work = 1'b1;
      c.status = ST_DONE;
      unique case (req_type)
         REQ_SRC_WR: ;
         REQ_FILL: bad = (x_first > x_last) || (y_first > y_last)
                         || ({25'd0, x_last} >= COLUMNS) || ({26'd0, y_last} >= ROWS);
         REQ_BLIT: begin
            if (!mono) begin
               c.work = 1'b0; c.status = ST_REFUSED;
            end else begin
               bad = (blit_width == '0) || (blit_height == '0)
                     || ({23'd0, xe} > COLUMNS) || ({24'd0, ye} > ROWS);
               // back walks from first to last inclusive
               c.x1 = 7'(xe - 9'd1);
               c.y1 = 6'(ye - 8'd1);
            end
         end
         REQ_FB_RD: bad = {22'd0, byte_addr} >= FB_BYTES;
         default: ;
      endcase
      if (bad) begin
         c.work = 1'b0; c.status = ST_INVALID;
      end
   end

   // two-entry queue
   cmd_type q_ff [2];
   logic [1:0] cnt_ff;
   logic rd_ff, wr_ff;
   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rd_ff];
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            q_ff[wr_ff] <= c; wr_ff <= ~wr_ff;
         end
         if (cmd_valid && cmd_ready) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'((req_valid && req_ready) ? 1 : 0)
                  - 2'((cmd_valid && cmd_ready) ? 1 : 0);
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !(cmd_valid))
      else $error("empty queue presents a command");
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == REQ_BLIT && !mono) |=> cnt_ff != 2'd0)
      else $error("refused blit lost");
endmodule

// ===== hw/rtl/pffb_back.sv =====
// Back end: executes fill, blit, source writes and reads on the stores.
// Depends on pffb_pkg and pffb_ram.
module pffb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  pffb_pkg::cmd_type cmd,
   input  logic [7:0]        stride,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        read_data,
   output logic [1:0]        status
);
   import pffb_pkg::*;
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_RD, S_MOD, S_BSRC, S_BMOD, S_RESP
   } state_type;

   state_type st_ff;
   cmd_type c_ff;
   logic [FB_AW-1:0] clr_ff;
   logic [6:0] col_ff;
   logic [5:0] row_ff;     // fill: a row in the current page ; blit: current row
   logic [7:0] acc_ff;     // blit: byte under construction
   logic [10:0] sc_ff;     // one bit past the field so the column does not wrap
   logic [9:0] sr_ff;
   logic [7:0] rd_ff;
   logic [1:0] stat_ff;
   logic       rv_ff;

   logic fw_en, sw_en;
   logic [FB_AW-1:0] fw_a, fr_a;
   logic [7:0] fw_d, fr_d, sr_d;
   logic [SRC_AW-1:0] sr_a;

   pffb_ram #(.WIDTH(8), .DEPTH(FB_BYTES)) u_fb (
      .clock, .wr_en(fw_en), .wr_addr(fw_a), .wr_data(fw_d),
      .rd_addr(fr_a), .rd_data(fr_d));
   pffb_ram #(.WIDTH(8), .DEPTH(SRC_DEPTH)) u_src (
      .clock, .wr_en(sw_en), .wr_addr(SRC_AW'(c_ff.addr)), .wr_data(c_ff.bin),
      .rd_addr(sr_a), .rd_data(sr_d));

   // row lies in one page; mask of rows in this page within [y0,y1]
   logic [5:0] pg_lo, pg_hi;
   logic [7:0] mask;
   logic [PG_W-1:0] pg;
   logic [19:0] prod;
   logic [2:0] sbit;
   logic pix;
   logic [7:0] acc_now;    // acc with this row's pixel merged in
   always_comb begin
      pg = PG_W'(row_ff >> 3);
      pg_lo = {row_ff[5:3], 3'd0};
      pg_hi = {row_ff[5:3], 3'd7};
      for (int i = 0; i < 8; i++)
         mask[i] = ((pg_lo + 6'(i)) >= c_ff.y0) && ((pg_lo + 6'(i)) <= c_ff.y1);
      fr_a = FB_AW'({col_ff, pg});
      if (st_ff == S_IDLE) fr_a = FB_AW'(cmd.addr);
      prod = sr_ff * stride;
      sr_a = SRC_AW'(prod[9:0] + {2'd0, sc_ff[10:3]});
      sbit = 3'(3'd7 - sc_ff[2:0]);
      pix = sr_d[sbit];
      acc_now = acc_ff;
      acc_now[row_ff[2:0]] = pix;
      fw_en = 1'b0; fw_a = FB_AW'({col_ff, pg}); fw_d = '0;
      unique case (st_ff)
         S_CLEAR: begin fw_en = 1'b1; fw_a = clr_ff; end
         S_MOD: begin
            fw_en = 1'b1;
            fw_d = c_ff.color ? (fr_d | mask) : (fr_d & ~mask);
         end
         S_BMOD: begin
            fw_en = (row_ff[2:0] == 3'd7) || (row_ff == c_ff.y1);
            fw_d = (fr_d & ~mask) | (acc_now & mask);
         end
         default: ;
      endcase
      sw_en = (st_ff == S_RD) && (c_ff.op == REQ_SRC_WR);
   end

   // next command waits until the pending result beat has left
   assign cmd_ready = (st_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign read_data = rd_ff;
   assign status = stat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR; clr_ff <= '0; rv_ff <= 1'b0;
      end else begin
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         unique case (st_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == FB_AW'(FB_BYTES - 1)) st_ff <= S_IDLE;
            end
            S_IDLE: if (cmd_valid && !rv_ff) begin
               c_ff <= cmd;
               col_ff <= cmd.x0;
               row_ff <= cmd.y0;
               sc_ff <= {1'b0, cmd.scol}; sr_ff <= cmd.srow; acc_ff <= '0;
               rd_ff <= '0; stat_ff <= cmd.status;
               if (!cmd.work) st_ff <= S_RESP;
               else if (cmd.op == REQ_BLIT) st_ff <= S_BSRC;
               else st_ff <= S_RD;
            end
            S_RD: begin
               // fb read of addr returns here; fill byte read issued; source write here
               if (c_ff.op == REQ_FB_RD) begin
                  rd_ff <= fr_d; st_ff <= S_RESP;
               end else if (c_ff.op == REQ_FILL) st_ff <= S_MOD;
               else st_ff <= S_RESP;
            end
            S_MOD: begin
               if (pg_hi >= c_ff.y1) begin
                  row_ff <= c_ff.y0;
                  if (col_ff == c_ff.x1) st_ff <= S_RESP;
                  else begin col_ff <= col_ff + 7'd1; st_ff <= S_RD; end
               end else begin
                  row_ff <= pg_lo + 6'd8; st_ff <= S_RD;
               end
            end
            S_BSRC: st_ff <= S_BMOD;   // source and fb reads in flight
            S_BMOD: begin
               acc_ff <= fw_en ? '0 : acc_now;
               if (row_ff == c_ff.y1) begin
                  row_ff <= c_ff.y0; sr_ff <= c_ff.srow;
                  sc_ff <= sc_ff + 11'd1;
                  if (col_ff == c_ff.x1) st_ff <= S_RESP;
                  else begin col_ff <= col_ff + 7'd1; st_ff <= S_BSRC; end
               end else begin
                  row_ff <= row_ff + 6'd1; sr_ff <= sr_ff + 10'd1;
                  st_ff <= S_BSRC;
               end
            end
            S_RESP: if (!rv_ff) begin
               rv_ff <= 1'b1; st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_CLEAR) |-> !cmd_ready)
      else $error("command taken during clear");
   assert property (@(posedge clock) disable iff (reset)
      fw_en |-> !(sw_en))
      else $error("both stores written at once");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_RESP && !rv_ff) |=> rv_ff)
      else $error("response dropped");
endmodule

// ===== hw/rtl/page_framebuffer_fill_and_blit.sv =====
// Channel  | ports                     | role
// req      | req_valid/req_ready + ...| command beat in
// rsp      | rsp_valid/rsp_ready + ...| one result beat per command
// csr      | csr_write/index/data      | stride and mono registers
// Fill reads and rewrites each touched fb byte (S_RD, S_MOD); blit reads source
// and fb for each pixel (S_BSRC, S_BMOD); source write and fb read use S_RD, S_RESP.
// After reset, a clearing pass zeroes the framebuffer before any command is taken.
// A two-entry queue decouples request from execution; rsp stalls hold the back end.
// Depends on pffb_pkg, pffb_front, pffb_back, pffb_ram.
module page_framebuffer_fill_and_blit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic       req_color,
   input  logic [6:0] req_x_first,
   input  logic [5:0] req_y_first,
   input  logic [6:0] req_x_last,
   input  logic [5:0] req_y_last,
   input  logic [9:0] req_src_col,
   input  logic [9:0] req_src_row,
   input  logic [7:0] req_blit_width,
   input  logic [6:0] req_blit_height,
   input  logic [9:0] req_byte_addr,
   input  logic [7:0] req_byte_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic [1:0] rsp_status,
   input  logic       csr_write,
   input  logic [7:0] csr_index,
   input  logic [7:0] csr_data
);
   import pffb_pkg::*;
   logic [7:0] stride_ff;
   logic mono_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= 8'd16; mono_ff <= 1'b1;
      end else if (csr_write) begin
         if (csr_index == CSR_STRIDE) stride_ff <= csr_data;
         if (csr_index == CSR_MONO) mono_ff <= csr_data[0];
      end
   end

   cmd_type cmd;
   logic cmd_valid, cmd_ready;
   pffb_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_type, .color(req_color),
      .x_first(req_x_first), .y_first(req_y_first), .x_last(req_x_last),
      .y_last(req_y_last), .src_col(req_src_col), .src_row(req_src_row),
      .blit_width(req_blit_width), .blit_height(req_blit_height),
      .byte_addr(req_byte_addr), .byte_in(req_byte_in), .mono(mono_ff),
      .cmd_valid, .cmd_ready, .cmd);
   pffb_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd, .stride(stride_ff),
      .rsp_valid, .rsp_ready, .read_data(rsp_read_data), .status(rsp_status));
endmodule
